// ===== hw/rtl/spt_pkg.sv =====
// Shared widths, codes, types and helpers of the spike peak and trigger unit.
`default_nettype none

package spt_pkg;

  // Field widths
  localparam int SAMPLE_W     = 32;               // width of sample and threshold fields
  localparam int SAMPLE_WIDTH = 32;               // bits actually used, sign-extended
  localparam int PEAK_W       = 31;
  localparam int TRIG_W       = 3;
  localparam int TIME_W       = 48;
  localparam int REL_W        = 60;
  localparam int NUM_CH       = 4;

  // Trigger channel codes
  localparam logic [TRIG_W-1:0] TRIG_X    = 3'd0;
  localparam logic [TRIG_W-1:0] TRIG_Y    = 3'd1;
  localparam logic [TRIG_W-1:0] TRIG_A    = 3'd2;
  localparam logic [TRIG_W-1:0] TRIG_B    = 3'd3;
  localparam logic [TRIG_W-1:0] TRIG_NONE = 3'd4;
  localparam logic [TRIG_W-1:0] TRIG_CODE [NUM_CH] = '{TRIG_X, TRIG_Y, TRIG_A, TRIG_B};

  // Relative time: round(mag * 2^FRAC_W / TICKS_PER_SEC). Both sides share a factor
  // of 16, so the work is round(mag * 4096 / 3125) = floor((mag*4096 + 1562) / 3125).
  localparam int TICKS_PER_SEC = 50000;
  localparam int FRAC_W        = 16;
  localparam int COMMON_SHIFT  = 4;
  localparam int DIVISOR       = TICKS_PER_SEC / (1 << COMMON_SHIFT);
  localparam int FINAL_SHIFT   = FRAC_W - COMMON_SHIFT;
  localparam int ROUND_TERM    = (TICKS_PER_SEC / 2) / (1 << COMMON_SHIFT);

  // Long division of the magnitude by DIVISOR, one 16-bit digit per step, then a
  // final step that appends the fraction bits.
  localparam int DIG_W       = 16;
  localparam int REM_W       = 12;
  localparam int X_W         = REM_W + DIG_W;
  localparam int NUM_STEPS   = TIME_W / DIG_W + 1;
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = 29;
  localparam int PROD_W      = X_W + RECIP_W;
  localparam longint RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;

  localparam logic [RECIP_W-1:0]     RECIP      = RECIP_W'(RECIP_VAL);
  localparam logic [X_W-1:0]         DIV_X      = X_W'(DIVISOR);
  localparam logic [FINAL_SHIFT-1:0] ROUND_BITS = FINAL_SHIFT'(ROUND_TERM);

  // One item moving through the result pipeline
  typedef struct packed {
    logic [NUM_CH-1:0][PEAK_W-1:0] peak;
    logic [TRIG_W-1:0]             trig;
    logic                          neg;
    logic [TIME_W-1:0]             mag;
    logic [REL_W-1:0]              qacc;
    logic [REM_W-1:0]              rem;
    logic [X_W-1:0]                x;
    logic [PROD_W-1:0]             prod;
  } pipe_t;

  // Sign-extend the low SAMPLE_WIDTH bits of a raw field
  function automatic logic signed [SAMPLE_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] raw);
    logic signed [SAMPLE_W-1:0] up;
    up = $signed(raw << (SAMPLE_W - SAMPLE_WIDTH));
    return up >>> (SAMPLE_W - SAMPLE_WIDTH);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spt_ifs.sv =====
// Valid/ready channel interfaces of the spike peak and trigger unit.
`default_nettype none

interface spt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [spt_pkg::SAMPLE_W-1:0] sample_x;
  logic signed [spt_pkg::SAMPLE_W-1:0] sample_y;
  logic signed [spt_pkg::SAMPLE_W-1:0] sample_a;
  logic signed [spt_pkg::SAMPLE_W-1:0] sample_b;
  logic signed [spt_pkg::SAMPLE_W-1:0] thresh_x;
  logic signed [spt_pkg::SAMPLE_W-1:0] thresh_y;
  logic signed [spt_pkg::SAMPLE_W-1:0] thresh_a;
  logic signed [spt_pkg::SAMPLE_W-1:0] thresh_b;
  logic        [spt_pkg::TIME_W-1:0]   timestamp;
  logic                                last_sample;

  modport source (
    output valid, sample_x, sample_y, sample_a, sample_b,
           thresh_x, thresh_y, thresh_a, thresh_b, timestamp, last_sample,
    input  ready
  );
  modport sink (
    input  valid, sample_x, sample_y, sample_a, sample_b,
           thresh_x, thresh_y, thresh_a, thresh_b, timestamp, last_sample,
    output ready
  );
endinterface

interface spt_out_if;
  logic                              valid;
  logic                              ready;
  logic        [spt_pkg::PEAK_W-1:0] peak_x;
  logic        [spt_pkg::PEAK_W-1:0] peak_y;
  logic        [spt_pkg::PEAK_W-1:0] peak_a;
  logic        [spt_pkg::PEAK_W-1:0] peak_b;
  logic        [spt_pkg::TRIG_W-1:0] trigger_channel;
  logic signed [spt_pkg::REL_W-1:0]  rel_seconds;

  modport source (
    output valid, peak_x, peak_y, peak_a, peak_b, trigger_channel, rel_seconds,
    input  ready
  );
  modport sink (
    input  valid, peak_x, peak_y, peak_a, peak_b, trigger_channel, rel_seconds,
    output ready
  );
endinterface

interface spt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spt_pkg::TIME_W-1:0]   offset_ticks;

  modport source (output valid, offset_ticks, input ready);
  modport sink (input valid, offset_ticks, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spike_peak_and_trigger_channel_unit.sv =====
// Top level of the spike peak and trigger unit: peak tracking, trigger search, time scaling.
`default_nettype none

// Takes one four-channel sample time per transfer and accepts a new transfer in every
// cycle while results are taken. Per channel it keeps a running peak floored at zero,
// and it remembers the first channel (x, y, a, b in that order) whose sample is
// strictly above its threshold. The transfer marked last_sample produces one result:
// the four peaks including that sample, the trigger channel (4 when none fired) and
// (timestamp - offset_ticks) in seconds with 16 fraction bits, rounded to nearest
// with ties away from zero. Peaks and trigger then restart for the next waveform.
// Other transfers produce no result. After the input register captures a transfer, its
// result passes through the peak/trigger stage, four long-division steps by 3125, each
// a multiply register and a digit register (three 16-bit quotient digits and a final
// 12-bit fraction digit, each via a 28x29 bit reciprocal multiply), and the output
// register. The whole pipeline holds while a result waits at the output, so throughput
// is one transfer per cycle only while results are taken.
// offset_ticks is written through cfg_ch, which is always ready; write it only while
// idle.

module spike_peak_and_trigger_channel_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spt_in_if.sink     in_ch,
  spt_out_if.source  out_ch,
  spt_cfg_if.sink    cfg_ch
);

  localparam int NS = spt_pkg::NUM_STEPS;

  // Pipeline advance: hold everything while a result waits at the output
  logic out_valid_r;
  logic adv;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [spt_pkg::TIME_W-1:0] offset_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_ch.valid) begin
      offset_r <= cfg_ch.offset_ticks;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                                v0_r;
  logic [spt_pkg::SAMPLE_W-1:0]        smp_r [spt_pkg::NUM_CH];
  logic [spt_pkg::SAMPLE_W-1:0]        thr_r [spt_pkg::NUM_CH];
  logic [spt_pkg::TIME_W-1:0]          ts_r;
  logic                                last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
  end

  // Capture payload on every advance; a bubble's payload is ignored downstream
  always_ff @(posedge clk) begin
    if (adv) begin
      smp_r[0] <= in_ch.sample_x;
      smp_r[1] <= in_ch.sample_y;
      smp_r[2] <= in_ch.sample_a;
      smp_r[3] <= in_ch.sample_b;
      thr_r[0] <= in_ch.thresh_x;
      thr_r[1] <= in_ch.thresh_y;
      thr_r[2] <= in_ch.thresh_a;
      thr_r[3] <= in_ch.thresh_b;
      ts_r     <= in_ch.timestamp;
      last_r   <= in_ch.last_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Peak and trigger tracking
  // ---------------------------------------------------------------------------
  logic [spt_pkg::NUM_CH-1:0][spt_pkg::PEAK_W-1:0] peak_r;
  logic [spt_pkg::NUM_CH-1:0][spt_pkg::PEAK_W-1:0] peak_nxt;
  logic [spt_pkg::TRIG_W-1:0]                      trig_r;
  logic [spt_pkg::TRIG_W-1:0]                      trig_nxt;
  logic signed [spt_pkg::SAMPLE_W-1:0]             smp_s [spt_pkg::NUM_CH];
  logic signed [spt_pkg::SAMPLE_W-1:0]             thr_s [spt_pkg::NUM_CH];

  always_comb begin
    for (int ch = 0; ch < spt_pkg::NUM_CH; ch++) begin
      smp_s[ch] = spt_pkg::sext_sample(smp_r[ch]);
      thr_s[ch] = spt_pkg::sext_sample(thr_r[ch]);
      // Peaks are never negative, so a larger sample fits in PEAK_W bits
      if (smp_s[ch] > $signed({1'b0, peak_r[ch]})) begin
        peak_nxt[ch] = smp_s[ch][spt_pkg::PEAK_W-1:0];
      end else begin
        peak_nxt[ch] = peak_r[ch];
      end
    end
  end

  // First channel over threshold wins, in x, y, a, b order
  always_comb begin
    trig_nxt = trig_r;
    for (int ch = 0; ch < spt_pkg::NUM_CH; ch++) begin
      if (trig_nxt == spt_pkg::TRIG_NONE && smp_s[ch] > thr_s[ch]) begin
        trig_nxt = spt_pkg::TRIG_CODE[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      trig_r <= spt_pkg::TRIG_NONE;
    end else if (adv && v0_r) begin
      // Restart tracking after the waveform's last sample
      if (last_r) begin
        peak_r <= '0;
        trig_r <= spt_pkg::TRIG_NONE;
      end else begin
        peak_r <= peak_nxt;
        trig_r <= trig_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result entry stage: capture peaks, trigger and time magnitude
  // ---------------------------------------------------------------------------
  logic                       v1_r;
  spt_pkg::pipe_t             p1_r;
  spt_pkg::pipe_t             p1_nxt;
  logic [spt_pkg::TIME_W-1:0] fwd_diff;
  logic [spt_pkg::TIME_W-1:0] bwd_diff;
  logic                       ts_neg;

  assign fwd_diff = ts_r - offset_r;
  assign bwd_diff = offset_r - ts_r;
  assign ts_neg   = ts_r < offset_r;

  always_comb begin
    p1_nxt      = '0;
    p1_nxt.peak = peak_nxt;
    p1_nxt.trig = trig_nxt;
    p1_nxt.neg  = ts_neg;
    p1_nxt.mag  = ts_neg ? bwd_diff : fwd_diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r && last_r;   // drop items that end no waveform
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= p1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Long division by 3125: per step, multiply by the reciprocal, then settle
  // quotient digit and remainder in the next stage
  // ---------------------------------------------------------------------------
  spt_pkg::pipe_t st_in  [NS];
  logic           vin    [NS];
  spt_pkg::pipe_t pm_r   [NS];
  spt_pkg::pipe_t pm_nxt [NS];
  logic           vm_r   [NS];
  spt_pkg::pipe_t ps_r   [NS];
  spt_pkg::pipe_t ps_nxt [NS];
  logic           vs_r   [NS];

  assign st_in[0] = p1_r;
  assign vin[0]   = v1_r;

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [spt_pkg::DIG_W-1:0] q_dig;
    logic [spt_pkg::X_W-1:0]   x_in;

    if (k > 0) begin : g_link
      assign st_in[k] = ps_r[k-1];
      assign vin[k]   = vs_r[k-1];
    end

    // Form the partial dividend: remainder, then next digit or rounding term
    if (k < NS - 1) begin : g_digit
      assign x_in = {st_in[k].rem,
                     st_in[k].mag[spt_pkg::TIME_W-1-spt_pkg::DIG_W*k -: spt_pkg::DIG_W]};
    end else begin : g_round
      assign x_in = spt_pkg::X_W'({st_in[k].rem, spt_pkg::ROUND_BITS});
    end

    always_comb begin
      pm_nxt[k]      = st_in[k];
      pm_nxt[k].x    = x_in;
      pm_nxt[k].prod = spt_pkg::PROD_W'(x_in) * spt_pkg::PROD_W'(spt_pkg::RECIP);
    end

    assign q_dig = pm_r[k].prod[spt_pkg::RECIP_SHIFT +: spt_pkg::DIG_W];

    // Append the quotient digit and keep the remainder for the next step
    always_comb begin
      ps_nxt[k]     = pm_r[k];
      ps_nxt[k].rem = spt_pkg::REM_W'(pm_r[k].x -
                                      spt_pkg::X_W'(spt_pkg::X_W'(q_dig) * spt_pkg::DIV_X));
      if (k < NS - 1) begin
        ps_nxt[k].qacc = {pm_r[k].qacc[spt_pkg::REL_W-spt_pkg::DIG_W-1:0], q_dig};
      end else begin
        ps_nxt[k].qacc = {pm_r[k].qacc[spt_pkg::REL_W-spt_pkg::FINAL_SHIFT-1:0],
                          q_dig[spt_pkg::FINAL_SHIFT-1:0]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vm_r[k] <= 1'b0;
        vs_r[k] <= 1'b0;
      end else if (adv) begin
        vm_r[k] <= vin[k];
        vs_r[k] <= vm_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pm_r[k] <= pm_nxt[k];
        ps_r[k] <= ps_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: apply the sign and present the result
  // ---------------------------------------------------------------------------
  logic [spt_pkg::NUM_CH-1:0][spt_pkg::PEAK_W-1:0] out_peak_r;
  logic [spt_pkg::TRIG_W-1:0]                      out_trig_r;
  logic [spt_pkg::REL_W-1:0]                       out_rel_r;
  logic [spt_pkg::REL_W-1:0]                       rel_nxt;

  assign rel_nxt = ps_r[NS-1].neg ? (~ps_r[NS-1].qacc + 1'b1) : ps_r[NS-1].qacc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_peak_r <= ps_r[NS-1].peak;
      out_trig_r <= ps_r[NS-1].trig;
      out_rel_r  <= rel_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.peak_x          = out_peak_r[0];
  assign out_ch.peak_y          = out_peak_r[1];
  assign out_ch.peak_a          = out_peak_r[2];
  assign out_ch.peak_b          = out_peak_r[3];
  assign out_ch.trigger_channel = out_trig_r;
  assign out_ch.rel_seconds     = $signed(out_rel_r);

endmodule

`default_nettype wire

// ===== verif/spt_summary_checker.sv =====
// Checker for the spike peak and trigger unit: predicts each spike summary and compares it.
`timescale 1ns / 1ps

module spt_summary_checker
  import spt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  spt_in_if    in_w,
  spt_out_if   out_w,
  spt_cfg_if   cfg_w,
  output int   fail_count,
  output int   pending,
  output int   sample_count,
  output int   summary_count
);

  typedef struct packed {
    logic [NUM_CH-1:0][PEAK_W-1:0] peak;
    logic [TRIG_W-1:0]             trig;
    logic [REL_W-1:0]              rel;
  } spike_summary_t;

  spike_summary_t    summary_q[$];
  logic [PEAK_W-1:0] peak_hold [NUM_CH];
  logic [TRIG_W-1:0] first_trig;
  logic [TIME_W-1:0] origin_ticks;
  int                errors;
  int                n_samples;
  int                n_summaries;

  // Sign-extend the used low bits of a nanovolt field.
  function automatic longint to_nv(input logic [SAMPLE_W-1:0] raw);
    logic signed [63:0] w;
    w = {32'd0, raw};
    w = w <<< (64 - SAMPLE_WIDTH);
    return w >>> (64 - SAMPLE_WIDTH);
  endfunction

  // (ts - origin) in seconds, 16 fraction bits, magnitude rounded half away from zero.
  function automatic logic [REL_W-1:0] ticks_to_seconds(input logic [TIME_W-1:0] ts,
                                                        input logic [TIME_W-1:0] org);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] q;
    neg = ts < org;
    mag = neg ? 64'(org - ts) : 64'(ts - org);
    q   = ((mag << FRAC_W) + 64'(TICKS_PER_SEC / 2)) / 64'(TICKS_PER_SEC);
    if (neg) begin
      q = -q;
    end
    return q[REL_W-1:0];
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10) begin
        $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    logic [SAMPLE_W-1:0] smp [NUM_CH];
    logic [SAMPLE_W-1:0] thr [NUM_CH];
    longint              s;
    longint              th;
    spike_summary_t      want;
    spike_summary_t      got;
    if (!rst_n) begin
      summary_q.delete();
      foreach (peak_hold[ch]) begin
        peak_hold[ch] = '0;
      end
      first_trig   = TRIG_NONE;
      origin_ticks = '0;
      errors       = 0;
      n_samples    = 0;
      n_summaries  = 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        origin_ticks = cfg_w.offset_ticks;
      end

      if (in_w.valid && in_w.ready) begin
        n_samples++;
        smp = '{in_w.sample_x, in_w.sample_y, in_w.sample_a, in_w.sample_b};
        thr = '{in_w.thresh_x, in_w.thresh_y, in_w.thresh_a, in_w.thresh_b};
        for (int ch = 0; ch < NUM_CH; ch++) begin
          s  = to_nv(smp[ch]);
          th = to_nv(thr[ch]);
          if (s > longint'({33'd0, peak_hold[ch]})) begin
            peak_hold[ch] = s[PEAK_W-1:0];
          end
          // strict compare: a sample equal to its threshold does not fire
          if (first_trig == TRIG_NONE && s > th) begin
            first_trig = TRIG_CODE[ch];
          end
        end
        if (in_w.last_sample) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            want.peak[ch] = peak_hold[ch];
            peak_hold[ch] = '0;
          end
          want.trig  = first_trig;
          want.rel   = ticks_to_seconds(in_w.timestamp, origin_ticks);
          first_trig = TRIG_NONE;
          summary_q  = {summary_q, want};
        end
      end

      if (out_w.valid && out_w.ready) begin
        n_summaries++;
        got.peak = {out_w.peak_b, out_w.peak_a, out_w.peak_y, out_w.peak_x};
        got.trig = out_w.trigger_channel;
        got.rel  = out_w.rel_seconds;
        if (summary_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] unexpected summary: peaks %0h %0h %0h %0h trig %0d rel 0x%0h",
                     $time, got.peak[0], got.peak[1], got.peak[2], got.peak[3],
                     got.trig, got.rel);
          end
        end else begin
          want = summary_q.pop_front();
          for (int ch = 0; ch < NUM_CH; ch++) begin
            check_field($sformatf("peak[%0d]", ch), 64'(want.peak[ch]), 64'(got.peak[ch]));
          end
          check_field("trigger_channel", 64'(want.trig), 64'(got.trig));
          check_field("rel_seconds", {4'd0, want.rel}, {4'd0, got.rel});
        end
      end
    end
    fail_count    <= errors;
    pending       <= summary_q.size();
    sample_count  <= n_samples;
    summary_count <= n_summaries;
  end

endmodule

// ===== verif/tb_spike_peak_and_trigger_channel_unit.sv =====
// Testbench top: clock, reset, sample stimulus, offset writes and the final verdict.
`timescale 1ns / 1ps

module tb_spike_peak_and_trigger_channel_unit;
  import spt_pkg::*;

  localparam logic [SAMPLE_W-1:0] NV_MAX       = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] NV_MIN       = 32'h8000_0000;
  localparam logic [TIME_W-1:0]   TS_MAX       = 48'hFFFF_FFFF_FFFF;
  localparam int                  DRAIN_CYCLES = 16;   // longer than the result latency
  localparam int                  QUIET_LIMIT  = 500;  // cycles with no transfer at all
  localparam int                  PHASE_ITEMS  = 140;
  localparam int                  NUM_PHASES   = 6;

  typedef struct {
    logic [SAMPLE_W-1:0] smp [NUM_CH];
    logic [SAMPLE_W-1:0] thr [NUM_CH];
    logic [TIME_W-1:0]   ts;
    logic                last;
  } sample_slot_t;

  logic              clk;
  logic              rst_n;
  logic [TIME_W-1:0] origin;      // stimulus-side copy of offset_ticks, for near-origin stamps
  int                rush_left;   // input transfers left in a back-to-back stretch
  int                cfg_writes;
  int                quiet;
  int                fail_count;
  int                pending;
  int                sample_count;
  int                summary_count;

  spt_in_if  in_ch ();
  spt_out_if out_ch ();
  spt_cfg_if cfg_ch ();

  spike_peak_and_trigger_channel_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  spt_summary_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_w          (in_ch),
    .out_w         (out_ch),
    .cfg_w         (cfg_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .sample_count  (sample_count),
    .summary_count (summary_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("spike_peak_and_trigger_channel_unit verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: hold ready low for a random stall before each summary, with occasional
  // stretches of no stalls at all. Take the first edge before driving high so
  // ready never gets two updates in one step.
  initial begin : result_side
    int stall;
    int calm_left;
    calm_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(0, 8);
        if ($urandom_range(0, 7) == 0) begin
          calm_left = $urandom_range(3, 12);
        end
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  function automatic sample_slot_t make_slot(
    input logic [SAMPLE_W-1:0] sx, sy, sa, sb, tx, ty, ta, tb,
    input logic [TIME_W-1:0]   ts,
    input logic                last
  );
    sample_slot_t s;
    s.smp  = '{sx, sy, sa, sb};
    s.thr  = '{tx, ty, ta, tb};
    s.ts   = ts;
    s.last = last;
    return s;
  endfunction

  // Mix full-range values with extremes and small values around zero.
  function automatic logic [SAMPLE_W-1:0] draw_nv();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return SAMPLE_W'($urandom_range(0, 2000) - 1000);
      2:       return $urandom_range(0, 1) ? NV_MAX : NV_MIN;
      3:       return {1'b0, 31'($urandom())};
      4:       return {1'b1, 31'($urandom())};
      default: return SAMPLE_W'($urandom_range(0, 100000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] draw_stamp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TS_MAX;
      2:       return origin;
      3, 4:    return origin + TIME_W'(int'($urandom_range(0, 140000)) - 70000);
      default: return TIME_W'({$urandom(), $urandom()});
    endcase
  endfunction

  // Keep thresholds close to the sample often, so equal, just-below and
  // just-above all come up per channel.
  function automatic sample_slot_t random_slot(input logic last);
    sample_slot_t s;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s.smp[ch] = draw_nv();
      case ($urandom_range(0, 7))
        0:       s.thr[ch] = s.smp[ch];
        1:       s.thr[ch] = s.smp[ch] - 1;
        2:       s.thr[ch] = s.smp[ch] + 1;
        3:       s.thr[ch] = NV_MAX;
        default: s.thr[ch] = draw_nv();
      endcase
    end
    s.ts   = draw_stamp();
    s.last = last;
    return s;
  endfunction

  // Present one sample time after a random gap and hold it until the transfer.
  task automatic stream_slot(input sample_slot_t s);
    int gap;
    if (rush_left > 0) begin
      gap = 0;
      rush_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) begin
        rush_left = $urandom_range(4, 20);
      end
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_x    <= s.smp[0];
    in_ch.sample_y    <= s.smp[1];
    in_ch.sample_a    <= s.smp[2];
    in_ch.sample_b    <= s.smp[3];
    in_ch.thresh_x    <= s.thr[0];
    in_ch.thresh_y    <= s.thr[1];
    in_ch.thresh_a    <= s.thr[2];
    in_ch.thresh_b    <= s.thr[3];
    in_ch.timestamp   <= s.ts;
    in_ch.last_sample <= s.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected summary, then let samples that make no
  // summary clear the pipeline.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_origin(input logic [TIME_W-1:0] v);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.offset_ticks <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    origin = v;
    cfg_writes++;
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] phase_origin [NUM_PHASES];
    int                wf_len;
    int                phase_items;
    logic              broken;

    origin     = '0;
    rush_left  = 0;
    cfg_writes = 0;

    // Drive every input to a known value while reset is held.
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.sample_x      <= '0;
    in_ch.sample_y      <= '0;
    in_ch.sample_a      <= '0;
    in_ch.sample_b      <= '0;
    in_ch.thresh_x      <= '0;
    in_ch.thresh_y      <= '0;
    in_ch.thresh_a      <= '0;
    in_ch.thresh_b      <= '0;
    in_ch.timestamp     <= '0;
    in_ch.last_sample   <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.offset_ticks <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, offset at its reset value of zero.
    // Most negative samples under the top threshold: no trigger, peaks floored at zero.
    stream_slot(make_slot(NV_MIN, NV_MIN, NV_MIN, NV_MIN,
                          NV_MAX, NV_MAX, NV_MAX, NV_MAX, '0, 1'b1));
    // Largest samples just above their thresholds: x wins, top timestamp.
    stream_slot(make_slot(NV_MAX, NV_MAX, NV_MAX, NV_MAX,
                          NV_MAX - 1, NV_MAX - 1, NV_MAX - 1, NV_MAX - 1, TS_MAX, 1'b1));
    // Samples equal to thresholds do not fire; y fires on the next sample time.
    stream_slot(make_slot(10, -5, 7, 0, 10, -5, 7, 0, 48'd999, 1'b0));
    stream_slot(make_slot(3, 21, 0, 0, 5, 20, 0, 0, 48'd1, 1'b1));
    // b fires first; a later x crossing must not replace it. Peaks carry over.
    stream_slot(make_slot(-4, -4, -4, -4, 0, 0, 0, 0, '0, 1'b0));
    stream_slot(make_slot(1, 2, 3, 900, 5, 5, 5, 899, '0, 1'b0));
    stream_slot(make_slot(1000, 0, 0, 0, 0, 0, 0, 0, 48'd3, 1'b1));
    // Only a fires; half a second exactly.
    stream_slot(make_slot(-10, -10, 500, -10, 0, 0, 499, 0, 48'd25000, 1'b1));
    // Negative samples above negative thresholds: trigger with all peaks zero.
    stream_slot(make_slot(-1, -1, -1, -1, -2, -2, -2, -2, 48'd50000, 1'b1));

    // Timestamps before, at and just under the largest offset.
    settle();
    write_origin(TS_MAX);
    stream_slot(make_slot(5, 5, 5, 5, 0, 0, 0, 0, '0, 1'b1));
    stream_slot(make_slot(0, 0, 0, 0, 0, 0, 0, 0, TS_MAX, 1'b1));
    stream_slot(make_slot(0, 0, 0, 0, 0, 0, 0, 0, TS_MAX - 1, 1'b1));

    // One tick either side of a mid offset, and seven ticks after it, exercise rounding of tiny magnitudes.
    settle();
    write_origin(48'd12345);
    stream_slot(make_slot(1, 0, 0, 0, 0, 0, 0, 0, 48'd12344, 1'b1));
    stream_slot(make_slot(0, 1, 0, 0, 0, 0, 0, 0, 48'd12346, 1'b1));
    stream_slot(make_slot(0, 0, 0, 1, 0, 0, 0, 0, 48'd12352, 1'b1));

    // Random part: one offset per phase, zero and the top value among them.
    phase_origin[0] = '0;
    phase_origin[1] = TS_MAX;
    phase_origin[2] = TIME_W'({$urandom(), $urandom()});
    phase_origin[3] = TIME_W'($urandom_range(0, 1000000));
    phase_origin[4] = TIME_W'({$urandom(), $urandom()});
    phase_origin[5] = 48'h8000_0000_0000;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      write_origin(phase_origin[phase]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // Mostly short waveforms, some long ones; now and then the last-sample
        // mark lands at random instead of on the final sample.
        wf_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < wf_len; k++) begin
          stream_slot(random_slot(broken ? 1'($urandom_range(0, 1)) : (k == wf_len - 1)));
          phase_items++;
        end
      end
    end

    settle();

    $display("covered %0d sample transfers and %0d spike summaries over %0d offset settings",
             sample_count, summary_count, cfg_writes + 1);
    $display("mismatches %0d, summaries still expected %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("spike_peak_and_trigger_channel_unit verification clean");
    end else begin
      $display("spike_peak_and_trigger_channel_unit verification failed");
    end
    $finish;
  end

endmodule
